FILE: design/vfcm_pkg.sv
// Shared types, codes and a lookup function for the voxel face-culling mesher.
package vfcm_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_MESH  = 2'd2,
      OP_BEGIN = 2'd3
   } vfcm_op_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SELF,
      ST_NBR,
      ST_TAIL,
      ST_EMIT
   } vfcm_state_type;

   // Face codes, in test order
   localparam logic [2:0] FACE_POS_Z = 3'd0;
   localparam logic [2:0] FACE_NEG_Z = 3'd1;
   localparam logic [2:0] FACE_NEG_X = 3'd2;
   localparam logic [2:0] FACE_POS_X = 3'd3;
   localparam logic [2:0] FACE_NEG_Y = 3'd4;
   localparam logic [2:0] FACE_POS_Y = 3'd5;
   localparam int NUM_FACES = 6;

   // Block types; grass, stone and dirt have their own atlas column
   localparam logic [2:0] TYPE_AIR   = 3'd0;
   localparam logic [2:0] TYPE_GRASS = 3'd1;
   localparam logic [2:0] TYPE_DIRT  = 3'd2;
   localparam logic [2:0] TYPE_STONE = 3'd3;

   localparam int VERT_WIDTH = 23;
   localparam logic [VERT_WIDTH-1:0] VERTS_PER_FACE = 23'd4;

   function automatic logic [1:0] tile_of(input logic [2:0] block_type);
      logic [1:0] col;
      case (block_type)
         TYPE_GRASS: col = 2'd0;
         TYPE_STONE: col = 2'd1;
         TYPE_DIRT:  col = 2'd2;
         default:    col = 2'd0;
      endcase
      return col;
   endfunction

endpackage

FILE: design/vfcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module vfcm_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/voxel_face_cull_mesher_core.sv
// Top level of the voxel face-culling mesher: voxel store, sequencer and result register.
//
// Usage:
//  - Request beats arrive on req_*: req_tuser carries the opcode (write, read, mesh one
//    block, begin pass), req_tdata the coordinates and the block type to write.
//  - Result beats leave on rsp_*: one per read, one per exposed face of a meshed block;
//    rsp_tlast marks the final beat caused by a request. Writes and begins give none.
//  - After reset the block sweeps the voxel store to air, one entry a cycle, over all
//    CHUNK_WIDTH*CHUNK_WIDTH*CHUNK_DEPTH_Y entries (65536 at the defaults). req_tready
//    stays low during the sweep. Vertex counter resets to 0, dirty flag to 1.
//  - One request is in work at a time; req_tready is high only when the sequencer idles.
//  - Write and begin finish on acceptance; a read goes through ST_READ to the result register.
//  - Mesh: one store read for the block, then one read per in-chunk neighbour on the single
//    read port (ST_SELF, ST_NBR, ST_TAIL), then one face beat per cycle while rsp_tready
//    allows; a block of air ends in ST_SELF and one outside the chunk ends at acceptance.
//  - The store read port serializes the mesh work; the result register is one deep.
//  - A stalled receiver (rsp_tready low) holds the result register and the sequencer
//    waits; no beat is dropped or repeated.
module voxel_face_cull_mesher_core #(
   parameter int CHUNK_WIDTH   = 16,
   parameter int CHUNK_DEPTH_Y = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   // [3:0] pos_x, [11:4] pos_y, [15:12] pos_z, [18:16] block_type, [23:19] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] read_type, [3] dirty, [6:4] face, [8:7] tile_column, [31:9] base_vertex
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   import vfcm_pkg::*;

   localparam int DEPTH = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_DEPTH_Y;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] STEP_Z   = AW'(CHUNK_WIDTH);
   localparam logic [AW-1:0] STEP_Y   = AW'(CHUNK_WIDTH * CHUNK_WIDTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

   // Request fields
   logic [3:0]  req_x;
   logic [7:0]  req_y;
   logic [3:0]  req_z;
   logic [2:0]  req_type;
   vfcm_op_type req_op;
   logic        req_in_chunk;
   logic [AW-1:0] req_idx;
   logic        accept;
   logic        out_free;

   assign req_x    = req_tdata[3:0];
   assign req_y    = req_tdata[11:4];
   assign req_z    = req_tdata[15:12];
   assign req_type = req_tdata[18:16];
   assign req_op   = vfcm_op_type'(req_tuser);

   assign req_in_chunk = (32'(req_x) < 32'(CHUNK_WIDTH)) &&
                         (32'(req_z) < 32'(CHUNK_WIDTH)) &&
                         (32'(req_y) < 32'(CHUNK_DEPTH_Y));
   // x + W*(z + W*y); only meaningful when in chunk
   assign req_idx = AW'(req_x) + STEP_Z * (AW'(req_z) + STEP_Z * AW'(req_y));

   // State
   vfcm_state_type state_ff, state_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic [AW-1:0]  cidx_ff, cidx_in;
   logic [3:0]     x_ff, x_in;
   logic [7:0]     y_ff, y_in;
   logic [3:0]     z_ff, z_in;
   logic           rd_oob_ff, rd_oob_in;
   logic [2:0]     self_type_ff, self_type_in;
   logic [2:0]     face_ff, face_in;
   logic           cap_valid_ff, cap_valid_in;
   logic [2:0]     cap_face_ff, cap_face_in;
   logic           cap_in_ff, cap_in_in;
   logic [NUM_FACES-1:0] mask_ff, mask_in;
   logic [VERT_WIDTH-1:0] vcount_ff, vcount_in;
   logic           dirty_ff, dirty_in;

   // Result register
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_last_ff, rsp_last_in;

   // Store port
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [2:0]    mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [2:0]    mem_rdata;

   vfcm_ram #(
      .WIDTH (3),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Neighbour of the face being issued: in-chunk test and store index
   logic          nb_in;
   logic [AW-1:0] nb_idx;

   always_comb begin
      nb_in  = 1'b0;
      nb_idx = cidx_ff;
      unique case (face_ff)
         FACE_POS_Z: begin
            nb_in  = (32'(z_ff) + 32'd1) < 32'(CHUNK_WIDTH);
            nb_idx = cidx_ff + STEP_Z;
         end
         FACE_NEG_Z: begin
            nb_in  = z_ff != 4'd0;
            nb_idx = cidx_ff - STEP_Z;
         end
         FACE_NEG_X: begin
            nb_in  = x_ff != 4'd0;
            nb_idx = cidx_ff - AW'(1);
         end
         FACE_POS_X: begin
            nb_in  = (32'(x_ff) + 32'd1) < 32'(CHUNK_WIDTH);
            nb_idx = cidx_ff + AW'(1);
         end
         FACE_NEG_Y: begin
            nb_in  = y_ff != 8'd0;
            nb_idx = cidx_ff - STEP_Y;
         end
         FACE_POS_Y: begin
            nb_in  = (32'(y_ff) + 32'd1) < 32'(CHUNK_DEPTH_Y);
            nb_idx = cidx_ff + STEP_Y;
         end
         default: begin
            nb_in  = 1'b0;
            nb_idx = cidx_ff;
         end
      endcase
   end

   // Lowest pending exposed face
   logic [2:0]           emit_face;
   logic [NUM_FACES-1:0] emit_bit;

   always_comb begin
      emit_face = FACE_POS_Z;
      emit_bit  = '0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            emit_face = 3'(i);
            emit_bit  = NUM_FACES'(1) << i;
         end
      end
   end

   // Ready only while the sequencer idles
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      cidx_in      = cidx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      rd_oob_in    = rd_oob_ff;
      self_type_in = self_type_ff;
      face_in      = face_ff;
      cap_valid_in = 1'b0;
      cap_face_in  = face_ff;
      cap_in_in    = nb_in;
      mask_in      = mask_ff;
      vcount_in    = vcount_ff;
      dirty_in     = dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      mem_we       = 1'b0;
      mem_waddr    = req_idx;
      mem_wdata    = req_type;
      mem_re       = 1'b0;
      mem_raddr    = req_idx;

      // neighbour data returned from last cycle's read
      if (cap_valid_ff) begin
         mask_in[cap_face_ff] = !cap_in_ff || (mem_rdata == TYPE_AIR);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            mem_wdata   = TYPE_AIR;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               x_in      = req_x;
               y_in      = req_y;
               z_in      = req_z;
               cidx_in   = req_idx;
               rd_oob_in = !req_in_chunk;
               unique case (req_op)
                  OP_WRITE: begin
                     if (req_in_chunk) begin
                        mem_we   = 1'b1;
                        dirty_in = 1'b1;
                     end
                  end
                  OP_READ: begin
                     mem_re   = req_in_chunk;
                     state_in = ST_READ;
                  end
                  OP_MESH: begin
                     if (req_in_chunk) begin
                        mem_re   = 1'b1;
                        state_in = ST_SELF;
                     end
                  end
                  OP_BEGIN: begin
                     vcount_in = '0;
                     dirty_in  = 1'b0;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {23'd0, 2'd0, 3'd0, dirty_ff,
                               rd_oob_ff ? TYPE_AIR : mem_rdata};
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SELF: begin
            self_type_in = mem_rdata;
            face_in      = FACE_POS_Z;
            mask_in      = '0;
            state_in     = (mem_rdata == TYPE_AIR) ? ST_IDLE : ST_NBR;
         end
         ST_NBR: begin
            // issue one neighbour read a cycle (in-chunk only); the capture follows the registered read
            mem_re       = nb_in;
            mem_raddr    = nb_idx;
            cap_valid_in = 1'b1;
            face_in      = face_ff + 3'd1;
            if (face_ff == FACE_POS_Y) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (mask_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {vcount_ff, tile_of(self_type_ff), emit_face, dirty_ff,
                               TYPE_AIR};
               rsp_last_in  = (mask_ff & ~emit_bit) == '0;
               mask_in      = mask_ff & ~emit_bit;
               vcount_in    = vcount_ff + VERTS_PER_FACE;
               if ((mask_ff & ~emit_bit) == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         cap_valid_ff <= 1'b0;
         vcount_ff    <= '0;
         dirty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         cap_valid_ff <= cap_valid_in;
         vcount_ff    <= vcount_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cidx_ff      <= cidx_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      rd_oob_ff    <= rd_oob_in;
      self_type_ff <= self_type_in;
      face_ff      <= face_in;
      cap_face_ff  <= cap_face_in;
      cap_in_ff    <= cap_in_in;
      mask_ff      <= mask_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
